>>> hdl/b64d_pkg.sv
`default_nettype none
package b64d_pkg;

  // Width of one decoded sextet and of the pending-sextet buffer.
  localparam int unsigned SEXTET_W = 6;
  localparam int unsigned BUF_W    = 18;

  // Width of the packed output word on the stream bus.
  localparam int unsigned OUT_DATA_W = 16;
  localparam int unsigned OUT_USER_W = 2;

  // Character classes after the alphabet look-up.
  typedef enum logic [1:0] {
    CHAR_SEXTET = 2'd0,
    CHAR_SKIP   = 2'd1,
    CHAR_STOP   = 2'd2
  } char_kind_t;

  typedef struct packed {
    char_kind_t           kind;
    logic [SEXTET_W-1:0]  sextet;
  } char_class_t;

  // One unit of work handed from the front end to the back end: up to three
  // result words produced by one accepted character.
  typedef struct packed {
    logic [2:0][7:0] bytes;      // bytes[0] goes out first
    logic [1:0]      last_idx;   // index of the final result word
    logic            byte_valid; // 0 for the empty end marker
    logic            msg_end;    // final word closes the message
    logic            stopped;    // decoding has halted in this message
  } b64d_job_t;

  // Maps one character to its sextet, or marks it as skipped or as a stop.
  function automatic char_class_t map_char(input logic [7:0] c, input logic url);
    char_class_t r;
    r.kind   = CHAR_STOP;
    r.sextet = '0;
    if (c >= 8'h41 && c <= 8'h5a) begin
      r.kind   = CHAR_SEXTET;
      r.sextet = 6'(c - 8'h41);
    end else if (c >= 8'h61 && c <= 8'h7a) begin
      r.kind   = CHAR_SEXTET;
      r.sextet = 6'(c - 8'h61 + 8'd26);
    end else if (c >= 8'h30 && c <= 8'h39) begin
      r.kind   = CHAR_SEXTET;
      r.sextet = 6'(c - 8'h30 + 8'd52);
    end else if (c == 8'h2b) begin
      r.kind   = CHAR_SEXTET;
      r.sextet = 6'd62;
    end else if (c == 8'h2f) begin
      r.kind   = CHAR_SEXTET;
      r.sextet = 6'd63;
    end else if (url && c == 8'h2d) begin
      r.kind   = CHAR_SEXTET;
      r.sextet = 6'd62;
    end else if (url && c == 8'h5f) begin
      r.kind   = CHAR_SEXTET;
      r.sextet = 6'd63;
    end else if (url && c == 8'h3d) begin
      r.kind   = CHAR_SKIP;
    end
    return r;
  endfunction

endpackage
`default_nettype wire

>>> hdl/b64d_front.sv
`default_nettype none
module b64d_front (
  input  wire logic               clk,
  input  wire logic               rst,
  // Configuration
  input  wire logic               cfg_valid,
  input  wire logic               cfg_data,
  // Input characters
  input  wire logic               in_valid,
  input  wire logic [7:0]         in_char,
  input  wire logic               in_last,
  output logic                    in_ready,
  // Job queue write side
  input  wire logic               queue_full,
  output logic                    job_push,
  output b64d_pkg::b64d_job_t     job
);

  logic                          url_mode;
  logic [b64d_pkg::BUF_W-1:0]    sbuf;
  logic [1:0]                    scount;
  logic                          halted;

  logic [b64d_pkg::BUF_W-1:0]    sbuf_next;
  logic [1:0]                    scount_next;
  logic                          halted_next;
  logic                          accept;
  logic                          group_done;
  logic [23:0]                   group;
  b64d_pkg::char_class_t         cls;

  assign in_ready = !queue_full;
  assign accept   = in_valid && in_ready;
  assign cls      = b64d_pkg::map_char(in_char, url_mode);

  // Decode one character against the pending sextets.
  always_comb begin
    sbuf_next   = sbuf;
    scount_next = scount;
    halted_next = halted;
    group_done  = 1'b0;
    group       = {sbuf, cls.sextet};
    if (!halted) begin
      if (cls.kind == b64d_pkg::CHAR_SEXTET) begin
        if (scount == 2'd3) begin
          group_done  = 1'b1;
          sbuf_next   = '0;
          scount_next = 2'd0;
        end else begin
          sbuf_next   = {sbuf[b64d_pkg::BUF_W-b64d_pkg::SEXTET_W-1:0], cls.sextet};
          scount_next = scount + 2'd1;
        end
      end else if (cls.kind == b64d_pkg::CHAR_STOP) begin
        halted_next = 1'b1;
      end
    end
  end

  // Build the job for the back end: a full group, or a flush at message end.
  always_comb begin
    job.bytes      = '0;
    job.last_idx   = 2'd0;
    job.byte_valid = 1'b1;
    job.msg_end    = in_last;
    job.stopped    = halted_next;
    job_push       = 1'b0;
    if (group_done) begin
      job.bytes[0] = group[23:16];
      job.bytes[1] = group[15:8];
      job.bytes[2] = group[7:0];
      job.last_idx = 2'd2;
      job_push     = accept;
    end else if (in_last) begin
      job_push = accept;
      unique case (scount_next)
        2'd2: begin
          job.bytes[0] = sbuf_next[11:4];
        end
        2'd3: begin
          job.bytes[0] = sbuf_next[17:10];
          job.bytes[1] = sbuf_next[9:2];
          job.last_idx = 2'd1;
        end
        default: begin
          job.byte_valid = 1'b0;
        end
      endcase
    end
  end

  // Decoder state; a message end returns it to the start of a message.
  always_ff @(posedge clk) begin
    if (rst) begin
      sbuf   <= '0;
      scount <= 2'd0;
      halted <= 1'b0;
    end else if (accept) begin
      if (in_last) begin
        sbuf   <= '0;
        scount <= 2'd0;
        halted <= 1'b0;
      end else begin
        sbuf   <= sbuf_next;
        scount <= scount_next;
        halted <= halted_next;
      end
    end
  end

  // Mode register.
  always_ff @(posedge clk) begin
    if (rst) begin
      url_mode <= 1'b0;
    end else if (cfg_valid) begin
      url_mode <= cfg_data;
    end
  end

endmodule
`default_nettype wire

>>> hdl/b64d_queue.sv
`default_nettype none
module b64d_queue #(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire b64d_pkg::b64d_job_t push_job,
  output logic                     full,
  input  wire logic                pop,
  output b64d_pkg::b64d_job_t      head,
  output logic                     empty
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  b64d_pkg::b64d_job_t entries [DEPTH];
  logic [PTR_W-1:0]    wr_ptr;
  logic [PTR_W-1:0]    rd_ptr;
  logic [CNT_W-1:0]    count;
  logic                do_push;
  logic                do_pop;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = entries[rd_ptr];

  // Storage.
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule
`default_nettype wire

>>> hdl/b64d_back.sv
`default_nettype none
module b64d_back (
  input  wire logic                clk,
  input  wire logic                rst,
  // Job queue read side
  input  wire logic                queue_empty,
  input  wire b64d_pkg::b64d_job_t head,
  output logic                     pop,
  // Result words
  output logic                     out_valid,
  input  wire logic                out_ready,
  output logic [7:0]               out_byte,
  output logic                     out_byte_valid,
  output logic                     out_run_last,
  output logic                     out_msg_end,
  output logic                     out_stopped
);

  b64d_pkg::b64d_job_t cur;
  logic                have;
  logic [1:0]          idx;
  logic                take;
  logic                final_word;

  assign out_valid      = have;
  assign take           = have && out_ready;
  assign final_word     = (idx == cur.last_idx);
  assign pop            = !queue_empty && (!have || (take && final_word));

  assign out_byte       = cur.bytes[idx];
  assign out_byte_valid = cur.byte_valid;
  assign out_run_last   = final_word;
  assign out_msg_end    = final_word && cur.msg_end;
  assign out_stopped    = cur.stopped;

  // Job payload; loaded whenever the queue head is taken.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= head;
    end
  end

  // Word sequencing through the current job.
  always_ff @(posedge clk) begin
    if (rst) begin
      have <= 1'b0;
      idx  <= 2'd0;
    end else if (pop) begin
      have <= 1'b1;
      idx  <= 2'd0;
    end else if (take && final_word) begin
      have <= 1'b0;
    end else if (take) begin
      idx <= idx + 2'd1;
    end
  end

endmodule
`default_nettype wire

>>> hdl/base64_stream_decoder_top.sv
`default_nettype none
// Streaming base64 decoder. One text character is accepted per cycle; every
// fourth alphabet character gives three decoded bytes, and a character marked
// with tlast flushes a partial group (n characters give n-1 bytes) or gives an
// empty end marker with byte_valid low. Each output word carries one byte, so
// a full group occupies the output for three words, and the sustained input
// rate is one character per cycle up to the point where the output port, at
// one word per cycle, becomes the limit. Each job waits in the queue and is then
// loaded into the back end's job register. Input and output are parted by a job
// queue of QUEUE_DEPTH entries; the input stalls only when that queue is full.
// In standard mode '=' or any non-alphabet byte halts decoding until the
// message end; with url_safe_mode set, '-' and '_' decode as 62 and 63 and
// '=' is skipped. The mode register is written through the cfg channel.
module base64_stream_decoder_top #(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  // Configuration: bit 0 is url_safe_mode
  input  wire logic                              cfg_valid,
  output logic                                   cfg_ready,
  input  wire logic                              cfg_data,
  // Input characters
  input  wire logic                              s_axis_tvalid,
  output logic                                   s_axis_tready,
  input  wire logic [7:0]                        s_axis_tdata,  // [7:0] text_char
  input  wire logic                              s_axis_tlast,  // message_last
  // Decoded words
  output logic                                   m_axis_tvalid,
  input  wire logic                              m_axis_tready,
  output logic [b64d_pkg::OUT_DATA_W-1:0]        m_axis_tdata,  // [7:0] data_byte, [8] run_last
  output logic [b64d_pkg::OUT_USER_W-1:0]        m_axis_tuser,  // [0] byte_valid, [1] stopped_early
  output logic                                   m_axis_tlast   // message_end
);

  b64d_pkg::b64d_job_t push_job;
  b64d_pkg::b64d_job_t head;
  logic                push;
  logic                pop;
  logic                full;
  logic                empty;
  logic [7:0]          out_byte;
  logic                out_byte_valid;
  logic                out_run_last;
  logic                out_stopped;

  assign cfg_ready = 1'b1;

  // Front end: alphabet look-up and sextet gathering.
  b64d_front u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_data   (cfg_data),
    .in_valid   (s_axis_tvalid),
    .in_char    (s_axis_tdata),
    .in_last    (s_axis_tlast),
    .in_ready   (s_axis_tready),
    .queue_full (full),
    .job_push   (push),
    .job        (push_job)
  );

  // Job queue between the two halves.
  b64d_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  // Back end: one byte per output word.
  b64d_back u_back (
    .clk            (clk),
    .rst            (rst),
    .queue_empty    (empty),
    .head           (head),
    .pop            (pop),
    .out_valid      (m_axis_tvalid),
    .out_ready      (m_axis_tready),
    .out_byte       (out_byte),
    .out_byte_valid (out_byte_valid),
    .out_run_last   (out_run_last),
    .out_msg_end    (m_axis_tlast),
    .out_stopped    (out_stopped)
  );

  // Output packing.
  assign m_axis_tdata = {{(b64d_pkg::OUT_DATA_W - 9){1'b0}}, out_run_last, out_byte};
  assign m_axis_tuser = {out_stopped, out_byte_valid};

endmodule
`default_nettype wire

>>> hdl/b64d_checker.sv
`default_nettype none
module b64d_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              m_axis_tvalid,
  input wire logic                              m_axis_tready,
  input wire logic [b64d_pkg::OUT_DATA_W-1:0]   m_axis_tdata,
  input wire logic [b64d_pkg::OUT_USER_W-1:0]   m_axis_tuser,
  input wire logic                              m_axis_tlast
);

  // A stalled output word holds still.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
      && $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  // The message end is always the last word of its character's run.
  a_end_run: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && m_axis_tlast |-> m_axis_tdata[8])
    else $error("message end without run end");

  // An empty marker carries a zero byte and closes the message.
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tdata[7:0] == 8'h00 && m_axis_tlast)
    else $error("malformed empty marker");

  // Nothing is offered straight after reset.
  a_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid after reset");

endmodule

bind base64_stream_decoder_top b64d_checker u_checker (
  .clk           (clk),
  .rst           (rst),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast)
);
`default_nettype wire

>>> test/tb_base64_stream_decoder_top.sv
`default_nettype none
module tb_base64_stream_decoder_top;

  // One decoded word as it leaves the block.
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       run_last;
    logic       message_end;
    logic       stopped_early;
  } dec_word_t;

  // One row of the directed table: either a mode write or a character.
  typedef struct packed {
    logic       is_cfg;
    logic [7:0] ch;
    logic       last;
    logic       typed;
    dec_word_t  w;
  } row_t;

  localparam int unsigned IDLE_LIMIT = 3000;
  localparam int unsigned TAIL_CYCLES = 6;
  localparam int unsigned N_DIR = 27;

  localparam dec_word_t NO_WORD = '0;
  localparam dec_word_t END_MARK = '{8'h00, 1'b0, 1'b1, 1'b1, 1'b0};
  localparam dec_word_t STOP_MARK = '{8'h00, 1'b0, 1'b1, 1'b1, 1'b1};

  localparam row_t DIR_ROWS [N_DIR] = '{
    '{1'b0, "A", 1'b1, 1'b1, END_MARK},
    '{1'b0, "T", 1'b0, 1'b0, NO_WORD},
    '{1'b0, "W", 1'b0, 1'b0, NO_WORD},
    '{1'b0, "F", 1'b0, 1'b0, NO_WORD},
    '{1'b0, "u", 1'b0, 1'b0, NO_WORD},
    '{1'b0, "=", 1'b1, 1'b1, STOP_MARK},
    '{1'b0, "/", 1'b0, 1'b0, NO_WORD},
    '{1'b0, "/", 1'b0, 1'b0, NO_WORD},
    '{1'b0, "/", 1'b0, 1'b0, NO_WORD},
    '{1'b0, "+", 1'b1, 1'b0, NO_WORD},
    '{1'b0, "A", 1'b0, 1'b0, NO_WORD},
    '{1'b0, "A", 1'b0, 1'b0, NO_WORD},
    '{1'b0, "A", 1'b0, 1'b0, NO_WORD},
    '{1'b0, 8'hff, 1'b1, 1'b0, NO_WORD},
    '{1'b0, 8'h80, 1'b1, 1'b1, STOP_MARK},
    '{1'b0, "z", 1'b0, 1'b0, NO_WORD},
    '{1'b0, "9", 1'b0, 1'b0, NO_WORD},
    '{1'b0, "-", 1'b0, 1'b0, NO_WORD},
    '{1'b0, "A", 1'b1, 1'b1, '{8'hcf, 1'b1, 1'b1, 1'b1, 1'b1}},
    '{1'b1, 8'h01, 1'b0, 1'b0, NO_WORD},
    '{1'b0, "-", 1'b0, 1'b0, NO_WORD},
    '{1'b0, "_", 1'b0, 1'b0, NO_WORD},
    '{1'b0, "=", 1'b0, 1'b0, NO_WORD},
    '{1'b0, "A", 1'b0, 1'b0, NO_WORD},
    '{1'b0, "=", 1'b1, 1'b0, NO_WORD},
    '{1'b0, ".", 1'b1, 1'b1, STOP_MARK},
    '{1'b0, 8'h00, 1'b1, 1'b1, STOP_MARK}
  };

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_data = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = '0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [b64d_pkg::OUT_DATA_W-1:0] m_axis_tdata;
  logic [b64d_pkg::OUT_USER_W-1:0] m_axis_tuser;
  logic        m_axis_tlast;

  // Travels alongside the character: a hand-typed word replaces the prediction.
  logic        row_typed = 1'b0;
  dec_word_t   row_word = '0;

  // Decoder state as the testbench sees it.
  logic [17:0] pend_sextets = '0;
  logic [1:0]  pend_count = '0;
  logic        dec_halted = 1'b0;
  logic        url_mode = 1'b0;

  dec_word_t   pending_words [$];
  int          errors = 0;
  int          idle_cycles = 0;
  int          send_gap_pct = 0;
  int          recv_gap_pct = 0;
  int          hold_cycles = 0;

  base64_stream_decoder_top uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_data     (cfg_data),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Appends one word to the list of words still expected.
  function automatic void add_expected(input dec_word_t x);
    pending_words.insert(pending_words.size(), x);
  endfunction

  // Classifies one character under the given alphabet.
  function automatic b64d_pkg::char_kind_t classify(input logic [7:0] c, input logic url,
                                                    output logic [5:0] sx);
    b64d_pkg::char_kind_t k;
    k = b64d_pkg::CHAR_SEXTET;
    sx = '0;
    if (c >= "A" && c <= "Z") sx = 6'(c - "A");
    else if (c >= "a" && c <= "z") sx = 6'(c - "a" + 26);
    else if (c >= "0" && c <= "9") sx = 6'(c - "0" + 52);
    else if (c == "+" || (url && c == "-")) sx = 6'd62;
    else if (c == "/" || (url && c == "_")) sx = 6'd63;
    else if (url && c == "=") k = b64d_pkg::CHAR_SKIP;
    else k = b64d_pkg::CHAR_STOP;
    return k;
  endfunction

  // Advances the decoder state by one character and queues the words it gives.
  function automatic void decode_char(input logic [7:0] c, input logic last,
                                      input bit keep);
    dec_word_t  w [3];
    int         n;
    logic [5:0] sx;
    logic [23:0] grp;
    b64d_pkg::char_kind_t k;
    n = 0;
    for (int i = 0; i < 3; i++) w[i] = '0;
    if (!dec_halted) begin
      k = classify(c, url_mode, sx);
      if (k == b64d_pkg::CHAR_SEXTET) begin
        if (pend_count == 2'd3) begin
          grp = {pend_sextets, sx};
          w[0].data_byte = grp[23:16];
          w[1].data_byte = grp[15:8];
          w[2].data_byte = grp[7:0];
          for (int i = 0; i < 3; i++) w[i].byte_valid = 1'b1;
          n = 3;
          pend_sextets = '0;
          pend_count = '0;
        end else begin
          pend_sextets = {pend_sextets[11:0], sx};
          pend_count = pend_count + 2'd1;
        end
      end else if (k == b64d_pkg::CHAR_STOP) begin
        dec_halted = 1'b1;
      end
    end
    for (int i = 0; i < 3; i++) w[i].stopped_early = dec_halted;
    // A message end flushes whatever partial group is left.
    if (last) begin
      if (n == 0) begin
        if (pend_count == 2'd2) begin
          w[0].data_byte = pend_sextets[11:4];
          w[0].byte_valid = 1'b1;
          n = 1;
        end else if (pend_count == 2'd3) begin
          w[0].data_byte = pend_sextets[17:10];
          w[1].data_byte = pend_sextets[9:2];
          w[0].byte_valid = 1'b1;
          w[1].byte_valid = 1'b1;
          n = 2;
        end else begin
          n = 1;
        end
      end
      w[n-1].message_end = 1'b1;
      pend_sextets = '0;
      pend_count = '0;
      dec_halted = 1'b0;
    end
    if (n > 0) w[n-1].run_last = 1'b1;
    if (keep) for (int i = 0; i < n; i++) add_expected(w[i]);
  endfunction

  // Tracks every handshake: mode writes, accepted characters and output words.
  always @(posedge clk) begin
    dec_word_t exp_w;
    dec_word_t got_w;
    if (!rst) begin
      if (cfg_valid && cfg_ready) url_mode = cfg_data;
      if (s_axis_tvalid && s_axis_tready) begin
        decode_char(s_axis_tdata, s_axis_tlast, !row_typed);
        if (row_typed) add_expected(row_word);
      end
      if (m_axis_tvalid && m_axis_tready) begin
        got_w = '{m_axis_tdata[7:0], m_axis_tuser[0], m_axis_tdata[8], m_axis_tlast,
                  m_axis_tuser[1]};
        if (pending_words.size() == 0) begin
          $error("unexpected word: %h", got_w);
          errors++;
        end else begin
          exp_w = pending_words.pop_front();
          if (got_w.data_byte !== exp_w.data_byte) begin
            $error("data_byte: expected %h, got %h", exp_w.data_byte, got_w.data_byte);
            errors++;
          end
          if (got_w.byte_valid !== exp_w.byte_valid) begin
            $error("byte_valid: expected %b, got %b", exp_w.byte_valid, got_w.byte_valid);
            errors++;
          end
          if (got_w.run_last !== exp_w.run_last) begin
            $error("run_last: expected %b, got %b", exp_w.run_last, got_w.run_last);
            errors++;
          end
          if (got_w.message_end !== exp_w.message_end) begin
            $error("message_end: expected %b, got %b", exp_w.message_end,
                   got_w.message_end);
            errors++;
          end
          if (got_w.stopped_early !== exp_w.stopped_early) begin
            $error("stopped_early: expected %b, got %b", exp_w.stopped_early,
                   got_w.stopped_early);
            errors++;
          end
        end
      end
      // Watchdog on a stretch with no handshake at all.
      if ((cfg_valid && cfg_ready) || (s_axis_tvalid && s_axis_tready) ||
          (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end
    end
  end

  // Output back-pressure: random stalls, or a long hold-off when requested.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_cycles != 0) begin
        m_axis_tready <= 1'b0;
        repeat (hold_cycles) @(posedge clk);
        hold_cycles = 0;
      end else begin
        m_axis_tready <= ($urandom_range(0, 99) >= recv_gap_pct);
      end
    end
  end

  // Offers one character and returns at the edge where it is taken.
  task automatic send_char(input logic [7:0] c, input logic last, input logic typed,
                           input dec_word_t w);
    while ($urandom_range(0, 99) < send_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= c;
    s_axis_tlast <= last;
    row_typed <= typed;
    row_word <= w;
    do @(posedge clk); while (!s_axis_tready);
  endtask

  // Stops sending and waits until every expected word has come out.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_words.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_mode(input logic v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // An alphabet character of the current mode, picked evenly over the sextets.
  function automatic logic [7:0] pick_alpha(input logic url);
    int unsigned r;
    r = $urandom_range(0, 63);
    if (r < 26) return 8'(r + "A");
    if (r < 52) return 8'(r - 26 + "a");
    if (r < 62) return 8'(r - 52 + "0");
    if (r == 62) return (url && $urandom_range(0, 1)) ? "-" : "+";
    return (url && $urandom_range(0, 1)) ? "_" : "/";
  endfunction

  // Mostly well-formed text, with some padding, URL characters and noise bytes.
  function automatic logic [7:0] pick_char();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 84) return pick_alpha(url_mode);
    if (r < 90) return "=";
    if (r < 94) return $urandom_range(0, 1) ? "-" : "_";
    return 8'($urandom_range(0, 255));
  endfunction

  initial begin
    int sent;
    int len;
    logic tail_last;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed table.
    send_gap_pct = 7;
    recv_gap_pct = 65;
    for (int i = 0; i < N_DIR; i++) begin
      if (DIR_ROWS[i].is_cfg) begin
        drain();
        write_mode(DIR_ROWS[i].ch[0]);
      end else begin
        send_char(DIR_ROWS[i].ch, DIR_ROWS[i].last, DIR_ROWS[i].typed, DIR_ROWS[i].w);
      end
    end
    drain();

    // Random phases; the mode alternates and a message may span a mode change.
    for (int p = 0; p < 6; p++) begin
      case (p / 2)
        0: begin
          send_gap_pct = 7;
          recv_gap_pct = 65;
        end
        1: begin
          send_gap_pct = 65;
          recv_gap_pct = 7;
        end
        default: begin
          send_gap_pct = 0;
          recv_gap_pct = 0;
        end
      endcase
      write_mode(p[0]);
      sent = 0;
      while (sent < 50) begin
        len = $urandom_range(1, 16);
        tail_last = ($urandom_range(0, 9) != 0);
        for (int i = 0; i < len; i++)
          send_char(pick_char(), tail_last && (i == len - 1), 1'b0, NO_WORD);
        sent += len;
      end
      drain();
    end

    // Close any open message so the burst below decodes from a clean start.
    send_gap_pct = 0;
    recv_gap_pct = 0;
    send_char(pick_alpha(url_mode), 1'b1, 1'b0, NO_WORD);
    drain();

    // Long output hold-off while full groups keep arriving, then a full pause.
    hold_cycles = 80;
    for (int i = 0; i < 48; i++)
      send_char(pick_alpha(url_mode), i == 47, 1'b0, NO_WORD);
    drain();

    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
`default_nettype wire
